FILE: sv/rnsd_pkg.sv
// ----------------------------------------------------------------------------
// rnsd_pkg
// Types and constants shared by the readout nibble stream decoder.
// ----------------------------------------------------------------------------
package rnsd_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned QualW  = 4;
  localparam int unsigned NibW   = 4;
  localparam int unsigned PixW   = 24;
  localparam int unsigned HdrW   = 16;

  // qualifier codes (word bits 7..4)
  localparam logic [QualW-1:0] QUAL_IDLE      = 4'd0;
  localparam logic [QualW-1:0] QUAL_PIX_START = 4'd1;
  localparam logic [QualW-1:0] QUAL_PIX_END   = 4'd6;
  localparam logic [QualW-1:0] QUAL_CHIP_HDR  = 4'd7;
  localparam logic [QualW-1:0] QUAL_HDR_START = 4'd8;
  localparam logic [QualW-1:0] QUAL_HDR_END   = 4'd11;
  localparam logic [QualW-1:0] QUAL_TRL_START = 4'd12;
  localparam logic [QualW-1:0] QUAL_TRL_END   = 4'd15;

  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_CHIP_HDR = 2'd1,
    KIND_EVT_HDR  = 2'd2,
    KIND_EVT_TRL  = 2'd3
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [6:0]  col_x;
    logic [7:0]  row_y;
    logic [7:0]  pulse_height;
    logic [3:0]  chip_header_bits;
    logic [7:0]  event_number;
    logic        stack_full_flag;
    logic        reset_seen_flag;
    logic [5:0]  stack_count;
    logic [7:0]  trailer_flags;
    logic [1:0]  data_id;
    logic [5:0]  readback_data;
  } result_t;

endpackage

FILE: sv/rnsd_core.sv
// ----------------------------------------------------------------------------
// rnsd_core
// Holds the pixel, header and trailer accumulators and decodes one word.
// ----------------------------------------------------------------------------
module rnsd_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic [rnsd_pkg::WordW-1:0]      word_i,
  output rnsd_pkg::result_t               res_o
);

  logic [rnsd_pkg::QualW-1:0] qual;
  logic [rnsd_pkg::NibW-1:0]  nib;

  logic [rnsd_pkg::PixW-1:0] pix_q, pix_d, pix_shift;
  logic [rnsd_pkg::HdrW-1:0] hdr_q, hdr_d, hdr_shift;
  logic [rnsd_pkg::HdrW-1:0] trl_q, trl_d, trl_shift;

  logic [2:0] d4, d3, d2, d1, d0;
  logic [5:0] col_c;
  logic [8:0] row_r;
  logic [6:0] pix_x;
  logic [8:0] pix_y;
  logic [7:0] pix_ph;

  assign qual = word_i[7:4];
  assign nib  = word_i[3:0];

  assign pix_shift = {pix_q[rnsd_pkg::PixW-5:0], nib};
  assign hdr_shift = {hdr_q[rnsd_pkg::HdrW-5:0], nib};
  assign trl_shift = {trl_q[rnsd_pkg::HdrW-5:0], nib};

  // pixel address: five base-6 digits, most significant first
  assign d4 = pix_shift[23:21];
  assign d3 = pix_shift[20:18];
  assign d2 = pix_shift[17:15];
  assign d1 = pix_shift[14:12];
  assign d0 = pix_shift[11:9];

  always_comb begin
    col_c  = 6'(d4) * 6'd6 + 6'(d3);
    row_r  = 9'(d2) * 9'd36 + 9'(d1) * 9'd6 + 9'(d0);
    pix_x  = {col_c, 1'b0} + {6'b0, row_r[0]};
    pix_y  = 9'd80 - {1'b0, row_r[8:1]};
    pix_ph = {pix_shift[8:5], pix_shift[3:0]};
  end

  always_comb begin
    pix_d = pix_q;
    hdr_d = hdr_q;
    trl_d = trl_q;
    res_o = '0;
    if (qual == rnsd_pkg::QUAL_PIX_START) begin
      pix_d = {{(rnsd_pkg::PixW-rnsd_pkg::NibW){1'b0}}, nib};
    end else if (qual > rnsd_pkg::QUAL_PIX_START && qual <= rnsd_pkg::QUAL_PIX_END) begin
      pix_d = pix_shift;
    end else if (qual == rnsd_pkg::QUAL_HDR_START) begin
      hdr_d = {{(rnsd_pkg::HdrW-rnsd_pkg::NibW){1'b0}}, nib};
    end else if (qual > rnsd_pkg::QUAL_HDR_START && qual <= rnsd_pkg::QUAL_HDR_END) begin
      hdr_d = hdr_shift;
    end else if (qual == rnsd_pkg::QUAL_TRL_START) begin
      trl_d = {{(rnsd_pkg::HdrW-rnsd_pkg::NibW){1'b0}}, nib};
    end else if (qual > rnsd_pkg::QUAL_TRL_START) begin
      trl_d = trl_shift;
    end

    if (qual == rnsd_pkg::QUAL_PIX_END) begin
      res_o.valid        = 1'b1;
      res_o.kind         = rnsd_pkg::KIND_PIXEL;
      res_o.col_x        = pix_x;
      res_o.row_y        = pix_y[7:0];
      res_o.pulse_height = pix_ph;
    end else if (qual == rnsd_pkg::QUAL_CHIP_HDR) begin
      res_o.valid            = 1'b1;
      res_o.kind             = rnsd_pkg::KIND_CHIP_HDR;
      res_o.chip_header_bits = nib;
    end else if (qual == rnsd_pkg::QUAL_HDR_END) begin
      res_o.valid           = 1'b1;
      res_o.kind            = rnsd_pkg::KIND_EVT_HDR;
      res_o.event_number    = hdr_shift[15:8];
      res_o.stack_full_flag = hdr_shift[7];
      res_o.reset_seen_flag = hdr_shift[6];
      res_o.stack_count     = hdr_shift[5:0];
    end else if (qual == rnsd_pkg::QUAL_TRL_END) begin
      res_o.valid         = 1'b1;
      res_o.kind          = rnsd_pkg::KIND_EVT_TRL;
      res_o.trailer_flags = trl_shift[15:8];
      res_o.data_id       = trl_shift[7:6];
      res_o.readback_data = trl_shift[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
      hdr_q <= '0;
      trl_q <= '0;
    end else if (adv_i) begin
      pix_q <= pix_d;
      hdr_q <= hdr_d;
      trl_q <= trl_d;
    end
  end

endmodule

FILE: sv/readout_nibble_stream_decoder.sv
// ----------------------------------------------------------------------------
// readout_nibble_stream_decoder
// Decodes a stream of readout words into pixel, header and trailer results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: word_i with in_valid_i / in_ready_o. Bits 7..4 of a word
//   are the qualifier, bits 3..0 the data nibble; bits 15..8 are ignored.
//   Output channel: kind_o and the result fields with out_valid_o /
//   out_ready_i. Fields that do not belong to the result kind are zero.
//   A word that is taken is decoded from the input register, and its
//   result, if any, is presented from the result register.
//   Throughput: one word per cycle while the receiver does not stall; the
//   input register and the result register form a two-stage pipeline, and
//   the accumulators update as a word leaves the input register.
//   Words that only shift nibbles or are idle produce no transfer.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more word; in_ready_o drops once both are full.
//   Reset clears both stage valids and all three accumulators.
// ----------------------------------------------------------------------------
module readout_nibble_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [6:0]  col_x_o,
  output logic signed [7:0] row_y_o,
  output logic [7:0]  pulse_height_o,
  output logic [3:0]  chip_header_bits_o,
  output logic [7:0]  event_number_o,
  output logic        stack_full_flag_o,
  output logic        reset_seen_flag_o,
  output logic [5:0]  stack_count_o,
  output logic [7:0]  trailer_flags_o,
  output logic [1:0]  data_id_o,
  output logic [5:0]  readback_data_o
);

  logic                          s1_valid_q;
  logic [rnsd_pkg::WordW-1:0]    s1_word_q;
  logic                          s1_adv;
  rnsd_pkg::result_t             res;
  logic                          out_valid_q;
  rnsd_pkg::result_t             out_res_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  rnsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .word_i (s1_word_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= res.valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_word_q <= word_i;
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = out_res_q.kind;
  assign col_x_o            = out_res_q.col_x;
  assign row_y_o            = out_res_q.row_y;
  assign pulse_height_o     = out_res_q.pulse_height;
  assign chip_header_bits_o = out_res_q.chip_header_bits;
  assign event_number_o     = out_res_q.event_number;
  assign stack_full_flag_o  = out_res_q.stack_full_flag;
  assign reset_seen_flag_o  = out_res_q.reset_seen_flag;
  assign stack_count_o      = out_res_q.stack_count;
  assign trailer_flags_o    = out_res_q.trailer_flags;
  assign data_id_o          = out_res_q.data_id;
  assign readback_data_o    = out_res_q.readback_data;

  // a chip header word always produces a chip header transfer next cycle
  a_chip_hdr_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_word_q[7:4] == rnsd_pkg::QUAL_CHIP_HDR |=>
      out_valid_o && kind_o == rnsd_pkg::KIND_CHIP_HDR)
    else $error("chip header word produced no chip header result");

  // an idle word never produces a transfer
  a_idle_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_word_q[7:4] == rnsd_pkg::QUAL_IDLE |=> !out_valid_o)
    else $error("idle word produced a result");

  // non-pixel results carry zero pixel fields
  a_pixel_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != rnsd_pkg::KIND_PIXEL |->
      col_x_o == 7'd0 && row_y_o == 8'sd0 && pulse_height_o == 8'd0)
    else $error("pixel fields set on a non-pixel result");

  // a stalled result must not be replaced by the pipeline
  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> !$past(s1_adv))
    else $error("result register advanced while stalled");

  // pixel x never exceeds the largest address
  a_pixel_x_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == rnsd_pkg::KIND_PIXEL |-> col_x_o <= 7'd99)
    else $error("pixel x out of range");

endmodule
